// ===== sv/msrtt_pkg.sv =====
package msrtt_pkg;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 16;

    // Stream widths (whole bytes)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;

    // Item kinds
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_START  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOP   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd2;

    typedef logic [VAL_W-1:0] val_t;

endpackage

// ===== sv/multi_slot_repeat_timer_table_core.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: mode, slot, delay, repeats, start_now
// m_        out  m_tvalid/m_tready  m_tdata: status, given_slot, fire_mask
//
// A tick visits every slot (accept, each slot in turn on the shared
// count-down/reload unit, result load); a create walks up to the lowest
// free slot; delete, start and stop go through accept, op and result load.
// Reset (aresetn low, synchronous) frees every slot and empties the output.
// A result waiting on m_tready does not block the next input transfer; the
// walk of that next item stalls only at its result load.
module multi_slot_repeat_timer_table_core #(
    parameter int SLOTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] mode, [6:3] slot, [38:7] delay, [70:39] repeats, [71] start_now
    input  logic [msrtt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [5:2] given_slot, [21:6] fire_mask, [23:22] zero
    output logic [msrtt_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_OP,
        S_DONE
    } state_t;

    // Control state
    state_t                                state_reg, state_next;
    logic [SLOTS-1:0]                      occupied_reg, occupied_next;
    logic [SLOTS-1:0]                      running_reg, running_next;
    logic [IDX_W-1:0]                      idx_reg, idx_next;
    logic                                  m_tvalid_reg, m_tvalid_next;

    // Latched item
    logic [msrtt_pkg::MODE_W-1:0]          mode_reg, mode_next;
    logic [msrtt_pkg::SLOT_W-1:0]          slot_reg, slot_next;
    msrtt_pkg::val_t                       delay_reg, delay_next;
    msrtt_pkg::val_t                       repeats_reg, repeats_next;
    logic                                  start_now_reg, start_now_next;

    // Working result and output register
    logic [msrtt_pkg::STATUS_W-1:0]        status_reg, status_next;
    logic [msrtt_pkg::SLOT_W-1:0]          given_reg, given_next;
    logic [msrtt_pkg::MASK_W-1:0]          mask_reg, mask_next;
    logic [msrtt_pkg::STATUS_W-1:0]        out_status_reg, out_status_next;
    logic [msrtt_pkg::SLOT_W-1:0]          out_given_reg, out_given_next;
    logic [msrtt_pkg::MASK_W-1:0]          out_mask_reg, out_mask_next;

    // Per-slot value arrays; a free slot's remaining count reads as zero
    msrtt_pkg::val_t                       remaining_reg [SLOTS];
    msrtt_pkg::val_t                       reload_reg    [SLOTS];
    msrtt_pkg::val_t                       fires_reg     [SLOTS];

    logic                                  rem_we, rel_we, fires_we;
    msrtt_pkg::val_t                       rem_wdata, fires_wdata;

    // Current slot as seen by the shared unit
    logic                                  cur_occ, cur_run;
    msrtt_pkg::val_t                       cur_rem, cur_rel, cur_fires;
    logic [IDX_W-1:0]                      slot_idx;
    logic                                  slot_ok;
    logic                                  out_free;

    assign cur_occ   = occupied_reg[idx_reg];
    assign cur_run   = running_reg[idx_reg];
    assign cur_rem   = cur_occ ? remaining_reg[idx_reg] : '0;
    assign cur_rel   = reload_reg[idx_reg];
    assign cur_fires = fires_reg[idx_reg];

    assign slot_idx  = slot_reg[IDX_W-1:0];
    assign slot_ok   = ({1'b0, slot_reg} < 5'(SLOTS)) && occupied_reg[slot_idx];
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, out_mask_reg, out_given_reg, out_status_reg};

    // Sequencer and shared count-down / reload unit
    always_comb begin
        state_next      = state_reg;
        occupied_next   = occupied_reg;
        running_next    = running_reg;
        idx_next        = idx_reg;
        m_tvalid_next   = m_tvalid_reg;
        mode_next       = mode_reg;
        slot_next       = slot_reg;
        delay_next      = delay_reg;
        repeats_next    = repeats_reg;
        start_now_next  = start_now_reg;
        status_next     = status_reg;
        given_next      = given_reg;
        mask_next       = mask_reg;
        out_status_next = out_status_reg;
        out_given_next  = out_given_reg;
        out_mask_next   = out_mask_reg;
        rem_we          = 1'b0;
        rel_we          = 1'b0;
        fires_we        = 1'b0;
        rem_wdata       = cur_rem;
        fires_wdata     = cur_fires;

        // Output register drains independently
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next      = s_tdata[2:0];
                    slot_next      = s_tdata[6:3];
                    delay_next     = s_tdata[38:7];
                    repeats_next   = s_tdata[70:39];
                    start_now_next = s_tdata[71];
                    idx_next       = '0;
                    status_next    = msrtt_pkg::ST_OK;
                    given_next     = '0;
                    mask_next      = '0;
                    if (s_tdata[2:0] == msrtt_pkg::MODE_TICK ||
                        s_tdata[2:0] == msrtt_pkg::MODE_CREATE) begin
                        state_next = S_WALK;
                    end else begin
                        state_next = S_OP;
                    end
                end
            end
            S_WALK: begin
                if (mode_reg == msrtt_pkg::MODE_TICK) begin
                    // Count down, or fire and reload / free
                    if (cur_rem != '0) begin
                        rem_we    = 1'b1;
                        rem_wdata = cur_rem - 1'b1;
                    end else if (cur_run && cur_occ) begin
                        mask_next = mask_reg | (msrtt_pkg::MASK_W'(1) << idx_reg);
                        if (cur_fires == msrtt_pkg::val_t'(1)) begin
                            occupied_next[idx_reg] = 1'b0;
                            running_next[idx_reg]  = 1'b0;
                        end else begin
                            rem_we    = 1'b1;
                            rem_wdata = cur_rel;
                            if (cur_fires != '0) begin
                                fires_we    = 1'b1;
                                fires_wdata = cur_fires - 1'b1;
                            end
                        end
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_DONE;
                    end
                end else begin
                    // Create: stop at the lowest free slot, or report full after the last
                    if (!cur_occ) begin
                        occupied_next[idx_reg] = 1'b1;
                        running_next[idx_reg]  = start_now_reg;
                        rem_we      = 1'b1;
                        rem_wdata   = delay_reg;
                        rel_we      = 1'b1;
                        fires_we    = 1'b1;
                        fires_wdata = repeats_reg;
                        status_next = msrtt_pkg::ST_OK;
                        given_next  = msrtt_pkg::SLOT_W'(idx_reg);
                        state_next  = S_DONE;
                    end else if (idx_reg == LAST_IDX) begin
                        status_next = msrtt_pkg::ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_OP: begin
                unique case (mode_reg)
                    msrtt_pkg::MODE_DELETE: begin
                        if (slot_ok) begin
                            occupied_next[slot_idx] = 1'b0;
                            running_next[slot_idx]  = 1'b0;
                        end else begin
                            status_next = msrtt_pkg::ST_UNUSED;
                        end
                    end
                    msrtt_pkg::MODE_START: begin
                        if (slot_ok) begin
                            running_next[slot_idx] = 1'b1;
                        end else begin
                            status_next = msrtt_pkg::ST_UNUSED;
                        end
                    end
                    msrtt_pkg::MODE_STOP: begin
                        if (slot_ok) begin
                            running_next[slot_idx] = 1'b0;
                        end else begin
                            status_next = msrtt_pkg::ST_UNUSED;
                        end
                    end
                    default: begin
                        status_next = msrtt_pkg::ST_OK;
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE: begin
                // Load result once the output register is free
                if (out_free) begin
                    out_status_next = status_reg;
                    out_given_next  = given_reg;
                    out_mask_next   = mask_reg;
                    m_tvalid_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            occupied_reg <= '0;
            running_reg  <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            occupied_reg <= occupied_next;
            running_reg  <= running_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        mode_reg       <= mode_next;
        slot_reg       <= slot_next;
        delay_reg      <= delay_next;
        repeats_reg    <= repeats_next;
        start_now_reg  <= start_now_next;
        status_reg     <= status_next;
        given_reg      <= given_next;
        mask_reg       <= mask_next;
        out_status_reg <= out_status_next;
        out_given_reg  <= out_given_next;
        out_mask_reg   <= out_mask_next;
    end

    // Slot value arrays, written at the walk index
    always_ff @(posedge aclk) begin
        if (rem_we) begin
            remaining_reg[idx_reg] <= rem_wdata;
        end
        if (rel_we) begin
            reload_reg[idx_reg] <= delay_reg;
        end
        if (fires_we) begin
            fires_reg[idx_reg] <= fires_wdata;
        end
    end

endmodule
